>>> sv/ccsds_rs_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and gf(2^8) helpers for the ccsds rs(255,223) encoder
// no dependencies; the generator polynomial is built at elaboration

package ccsds_rs_pkg;

    localparam int unsigned NPAR      = 32;
    localparam int unsigned MSG_LEN   = 223;
    localparam int unsigned FCR       = 112;
    localparam int unsigned PRIM      = 11;
    localparam logic [7:0]  FIELD_LOW = 8'h87;

    localparam int unsigned CNT_W   = 8;
    localparam int unsigned DRAIN_W = $clog2(NPAR + 1);

    typedef logic [7:0]            t_byte;
    typedef logic [NPAR-1:0][7:0]  t_parity;
    typedef logic [NPAR:0][7:0]    t_gen;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [DRAIN_W-1:0]    t_drain_count;

    // multiply in gf(2^8), field polynomial 0x187
    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte r;
        t_byte x;
        t_byte y;
        logic  hi;
        r = '0;
        x = a;
        y = b;
        for (int k = 0; k < 8; k++) begin
            if (y[0]) begin
                r = r ^ x;
            end
            y  = y >> 1;
            hi = x[7];
            x  = {x[6:0], 1'b0};
            if (hi) begin
                x = x ^ FIELD_LOW;
            end
        end
        return r;
    endfunction

    function automatic t_byte alpha_pow(input int unsigned e);
        t_byte       v;
        int unsigned n;
        v = 8'h01;
        n = e % 255;
        for (int unsigned k = 0; k < n; k++) begin
            v = gf_mul(v, 8'h02);
        end
        return v;
    endfunction

    // roots alpha^(11*(112+i)), i = 0..31; g[0] is the constant term
    function automatic t_gen build_gen();
        t_gen  g;
        t_byte root;
        g    = '0;
        g[0] = 8'h01;
        for (int i = 0; i < NPAR; i++) begin
            root = alpha_pow(PRIM * (FCR + i));
            for (int j = i + 1; j > 0; j--) begin
                g[j] = g[j-1] ^ gf_mul(g[j], root);
            end
            g[0] = gf_mul(g[0], root);
        end
        return g;
    endfunction

    localparam t_gen GEN_POLY = build_gen();

endpackage

>>> sv/ccsds_rs_in_if.sv
`timescale 1ns / 1ps
// message byte channel: valid/ready handshake with one data byte per beat
// depends on ccsds_rs_pkg

interface ccsds_rs_in_if
    import ccsds_rs_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> sv/ccsds_rs_out_if.sv
`timescale 1ns / 1ps
// parity byte channel: valid/ready handshake, one parity byte and a last flag per beat
// depends on ccsds_rs_pkg

interface ccsds_rs_out_if
    import ccsds_rs_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte parity_byte;
    logic  last_parity;

    modport source (output valid, output parity_byte, output last_parity, input ready);
    modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

>>> sv/ccsds_rs_lfsr.sv
`timescale 1ns / 1ps
// byte-serial parity shift register with constant gf multipliers and message byte count
// depends on ccsds_rs_pkg

module ccsds_rs_lfsr
    import ccsds_rs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_byte   i_data_byte,
    output logic    o_done,
    output t_parity o_parity_next
);

    t_parity r_parity;
    t_parity n_parity;
    t_count  r_count;
    t_count  n_count;
    t_byte   feedback;

    assign o_done = (r_count == t_count'(MSG_LEN - 1));

    always_comb begin
        feedback = i_data_byte ^ r_parity[0];
        for (int j = 0; j < NPAR - 1; j++) begin
            o_parity_next[j] = r_parity[j+1] ^ gf_mul(GEN_POLY[NPAR-1-j], feedback);
        end
        o_parity_next[NPAR-1] = gf_mul(GEN_POLY[0], feedback);
    end

    always_comb begin
        n_parity = r_parity;
        n_count  = r_count;
        if (i_step) begin
            if (o_done) begin
                // codeword complete: parity goes to the drain, start afresh
                n_parity = '0;
                n_count  = '0;
            end else begin
                n_parity = o_parity_next;
                n_count  = r_count + t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= '0;
            r_count  <= '0;
        end else begin
            r_parity <= n_parity;
            r_count  <= n_count;
        end
    end

endmodule

>>> sv/ccsds_rs_drain.sv
`timescale 1ns / 1ps
// output shift register that hands out the 32 parity bytes of a finished codeword
// depends on ccsds_rs_pkg and ccsds_rs_out_if

module ccsds_rs_drain
    import ccsds_rs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_parity i_parity,
    output logic    o_busy,
    ccsds_rs_out_if.source o_out
);

    t_parity      r_drain;
    t_parity      n_drain;
    t_drain_count r_left;
    t_drain_count n_left;
    logic         take;

    assign o_busy            = (r_left != '0);
    assign o_out.valid       = o_busy;
    assign o_out.parity_byte = r_drain[0];
    assign o_out.last_parity = (r_left == t_drain_count'(1));
    assign take              = o_out.valid && o_out.ready;

    always_comb begin
        n_drain = r_drain;
        n_left  = r_left;
        if (i_load) begin
            n_drain = i_parity;
            n_left  = t_drain_count'(NPAR);
        end else if (take) begin
            n_drain = r_drain >> 8;
            n_left  = r_left - t_drain_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_drain <= n_drain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

endmodule

>>> sv/ccsds_rs_255_223_encoder_unit.sv
`timescale 1ns / 1ps
// ccsds rs(255,223) systematic parity encoder, top level
// depends on ccsds_rs_pkg, ccsds_rs_in_if, ccsds_rs_out_if, ccsds_rs_lfsr, ccsds_rs_drain
//
//  port   | direction | beat carries
//  -------+-----------+-------------------------------------------
//  i_in   | sink      | data_byte, one message byte
//  o_out  | source    | parity_byte, last_parity (on byte 31)
//
// one byte is taken per cycle while ready; the parity register updates in the same cycle
// the beat that completes a codeword moves the parity into a 32-byte output shift register,
// which drains a byte per cycle when o_out is ready while the next codeword's bytes are taken
// the final byte of a codeword is held off only while the previous parity still drains
// synchronous active-low reset clears the parity register, byte count and drain count

module ccsds_rs_255_223_encoder_unit
    import ccsds_rs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ccsds_rs_in_if.sink    i_in,
    ccsds_rs_out_if.source o_out
);

    logic    step;
    logic    done;
    logic    busy;
    t_parity parity_next;

    assign i_in.ready = !(done && busy);
    assign step       = i_in.valid && i_in.ready;

    ccsds_rs_lfsr u_lfsr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_data_byte   (i_in.data_byte),
        .o_done        (done),
        .o_parity_next (parity_next)
    );

    ccsds_rs_drain u_drain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && done),
        .i_parity (parity_next),
        .o_busy   (busy),
        .o_out    (o_out)
    );

endmodule
